### rtl/spte_pkg.sv
// spte_pkg: shared types and constants for the servo packet transaction engine.
// Used by every module under rtl/; depends on nothing.
package spte_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] BROADCAST_ID = 8'hFE;

  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);
  localparam int unsigned CMD_CNT_W       = $clog2(CMD_QUEUE_DEPTH + 1);

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 56;

  // input item selector
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_RXBYTE = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // finish status
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
  localparam logic [1:0] STATUS_ID       = 2'd2;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_SERVO_ID   = 2'd0;
  localparam logic [1:0] CFG_RETRY      = 2'd1;
  localparam logic [1:0] CFG_WAIT_TICKS = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HUNT1,
    PH_HUNT2,
    PH_BODY
  } phase_e;

  typedef enum logic [2:0] {
    POS_ID,
    POS_LEN,
    POS_ERR,
    POS_LO,
    POS_HI,
    POS_SUM
  } pos_e;

  typedef enum logic [3:0] {
    STEP_SYNC1,
    STEP_SYNC2,
    STEP_ID,
    STEP_LEN,
    STEP_INSTR,
    STEP_ADDR,
    STEP_LO,
    STEP_HI,
    STEP_CKSUM,
    STEP_FIN
  } step_e;

  typedef struct packed {
    logic [7:0]  servo_id;
    logic [3:0]  retry_limit;
    logic [15:0] wait_ticks;
  } cfg_t;

  // one queued job for the back end: an optional packet, an optional finish beat
  typedef struct packed {
    logic        pkt;
    logic        fin;
    logic [1:0]  status;
    logic [7:0]  err;
    logic [15:0] value;
    logic [15:0] failure;
    logic [7:0]  id;
    logic [7:0]  instr;
    logic [7:0]  addr;
    logic [15:0] arg;
    logic [1:0]  cnt;
    logic [7:0]  cksum;
  } cmd_t;

endpackage

### rtl/servo_packet_transaction_engine.sv
// servo_packet_transaction_engine: top level, configuration registers and
// wiring of spte_front, spte_cmd_queue and spte_back. Depends on spte_pkg.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser: operation; tdata: packet fields, rx_byte
//  m_axis    out  tvalid/tready/tlast    tuser: kind; tdata: byte, status, answer, count
//  cfg       in   cfg_we_i               cfg_idx_i selects register, cfg_data_i value
//
// The front end takes one input beat per cycle while the two-entry job queue has
// room; each beat queues at most one job. The back end emits one output beat per
// cycle while m_axis_tready is high; a start or retry job gives up to 9 packet
// bytes plus a finish beat for broadcast, and any other job a single finish beat.
// The output register holds while m_axis_tready is low; the queue then fills and
// s_axis_tready drops. Reset is asynchronous and needs no clearing pass.
module servo_packet_transaction_engine
  import spte_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // tuser: operation[1:0]
  // tdata: instruction[7:0], reg_address[15:8], argument[31:16], arg_count[33:32],
  //        rx_byte[41:34], zero fill
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: tx_byte[7:0], status_code[9:8], servo_error[17:10], read_value[33:18],
  //        failure_total[49:34], zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  // tuser: kind[0]
  output logic [0:0]             m_axis_tuser,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [15:0]            cfg_data_i
);

  cfg_t cfg_q;
  logic accept;
  logic push, pop, q_full, head_valid;
  cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_id    <= 8'd1;
      cfg_q.retry_limit <= 4'd3;
      cfg_q.wait_ticks  <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SERVO_ID:   cfg_q.servo_id    <= cfg_data_i[7:0];
        CFG_RETRY:      cfg_q.retry_limit <= cfg_data_i[3:0];
        CFG_WAIT_TICKS: cfg_q.wait_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  spte_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .operation_i   (s_axis_tuser),
    .instruction_i (s_axis_tdata[7:0]),
    .reg_address_i (s_axis_tdata[15:8]),
    .argument_i    (s_axis_tdata[31:16]),
    .arg_count_i   (s_axis_tdata[33:32]),
    .rx_byte_i     (s_axis_tdata[41:34]),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  spte_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  spte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_cmd_i    (head_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### rtl/spte_cmd_queue.sv
// spte_cmd_queue: short job queue between the front end and the back end.
// Depends on spte_pkg (cmd_t, depth constants).
module spte_cmd_queue
  import spte_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  cmd_t                 mem_q [CMD_QUEUE_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] count_q, count_d;

  assign full_o       = (count_q == CMD_CNT_W'(CMD_QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CMD_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("job queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CMD_CNT_W'(CMD_QUEUE_DEPTH))
    else $error("job queue count out of range");

endmodule

### rtl/spte_front.sv
// spte_front: accepts input beats, tracks the transaction (answer hunt, parse,
// timeout, retries) and queues jobs for the back end. Depends on spte_pkg.
module spte_front
  import spte_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        accept_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  instruction_i,
  input  logic [7:0]  reg_address_i,
  input  logic [15:0] argument_i,
  input  logic [1:0]  arg_count_i,
  input  logic [7:0]  rx_byte_i,
  output logic        push_o,
  output cmd_t        push_cmd_o
);

  phase_e      phase_q, phase_d;
  pos_e        pos_q, pos_d;
  logic [3:0]  attempt_q, attempt_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] fail_q, fail_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  high_q, high_d;

  // payload, written before read
  logic [7:0]  sv_instr_q, sv_addr_q;
  logic [15:0] sv_arg_q;
  logic [1:0]  sv_cnt_q;
  logic [7:0]  ans_id_q, ans_len_q, ans_err_q;
  logic        ld_id, ld_len, ld_err;

  logic        is_start;
  logic [7:0]  src_instr, src_addr, src_lo, src_hi;
  logic [1:0]  src_cnt;
  logic [7:0]  pkt_sum, ans_sum;
  logic        do_begin, do_fail;
  logic [1:0]  fail_code;
  logic [15:0] wait_inc;

  assign is_start  = (op_e'(operation_i) == OP_START);
  assign src_instr = is_start ? instruction_i : sv_instr_q;
  assign src_addr  = is_start ? reg_address_i : sv_addr_q;
  assign src_lo    = is_start ? argument_i[7:0] : sv_arg_q[7:0];
  assign src_hi    = is_start ? argument_i[15:8] : sv_arg_q[15:8];
  assign src_cnt   = is_start ? arg_count_i : sv_cnt_q;
  // all three parameter bytes count, sent or not
  assign pkt_sum   = cfg_i.servo_id + src_instr + src_addr + src_lo + src_hi
                   + 8'd2 + {6'd0, src_cnt};
  assign ans_sum   = ans_id_q + ans_len_q + ans_err_q + low_q + high_q;
  assign wait_inc  = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    attempt_d  = attempt_q;
    wait_d     = wait_q;
    fail_d     = fail_q;
    low_d      = low_q;
    high_d     = high_q;
    ld_id      = 1'b0;
    ld_len     = 1'b0;
    ld_err     = 1'b0;
    do_begin   = 1'b0;
    do_fail    = 1'b0;
    fail_code  = STATUS_OK;
    push_o     = 1'b0;
    push_cmd_o = '0;

    if (accept_i) begin
      unique case (op_e'(operation_i))
        OP_START: begin
          attempt_d = '0;
          do_begin  = 1'b1;
        end
        OP_RXBYTE: begin
          unique case (phase_q)
            PH_HUNT1: begin
              if (rx_byte_i == SYNC_BYTE) phase_d = PH_HUNT2;
            end
            PH_HUNT2: begin
              if (rx_byte_i == SYNC_BYTE) begin
                phase_d = PH_BODY;
                pos_d   = POS_ID;
                low_d   = '0;
                high_d  = '0;
              end else begin
                phase_d = PH_HUNT1;
              end
            end
            PH_BODY: begin
              unique case (pos_q)
                POS_ID: begin
                  ld_id = 1'b1;
                  pos_d = POS_LEN;
                end
                POS_LEN: begin
                  ld_len = 1'b1;
                  pos_d  = POS_ERR;
                end
                POS_ERR: begin
                  ld_err = 1'b1;
                  pos_d  = (ans_len_q > 8'd2) ? POS_LO : POS_SUM;
                end
                POS_LO: begin
                  low_d = rx_byte_i;
                  pos_d = (ans_len_q > 8'd3) ? POS_HI : POS_SUM;
                end
                POS_HI: begin
                  high_d = rx_byte_i;
                  pos_d  = POS_SUM;
                end
                default: begin
                  if (~ans_sum != rx_byte_i) begin
                    do_fail   = 1'b1;
                    fail_code = STATUS_CHECKSUM;
                  end else if (ans_id_q != cfg_i.servo_id) begin
                    do_fail   = 1'b1;
                    fail_code = STATUS_ID;
                  end else begin
                    push_o            = 1'b1;
                    push_cmd_o.fin    = 1'b1;
                    push_cmd_o.status = STATUS_OK;
                    push_cmd_o.err    = ans_err_q;
                    push_cmd_o.value  = {high_q, low_q};
                    phase_d           = PH_IDLE;
                  end
                end
              endcase
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            wait_d = wait_inc;
            // counts across the whole attempt, also mid-packet
            if (wait_inc >= cfg_i.wait_ticks) begin
              do_fail   = 1'b1;
              fail_code = STATUS_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end

    if (do_fail) begin
      fail_d = (fail_q == 16'hFFFF) ? fail_q : fail_q + 16'd1;
      if (attempt_q < cfg_i.retry_limit) begin
        attempt_d = attempt_q + 4'd1;
        do_begin  = 1'b1;
      end else begin
        push_o            = 1'b1;
        push_cmd_o.fin    = 1'b1;
        push_cmd_o.status = fail_code;
        phase_d           = PH_IDLE;
      end
    end

    if (do_begin) begin
      push_o           = 1'b1;
      push_cmd_o.pkt   = 1'b1;
      push_cmd_o.id    = cfg_i.servo_id;
      push_cmd_o.instr = src_instr;
      push_cmd_o.addr  = src_addr;
      push_cmd_o.arg   = {src_hi, src_lo};
      push_cmd_o.cnt   = src_cnt;
      push_cmd_o.cksum = ~pkt_sum;
      if (cfg_i.servo_id == BROADCAST_ID) begin
        push_cmd_o.fin    = 1'b1;
        push_cmd_o.status = STATUS_OK;
        phase_d           = PH_IDLE;
      end else begin
        phase_d = PH_HUNT1;
        wait_d  = '0;
        pos_d   = POS_ID;
      end
    end

    push_cmd_o.failure = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pos_q     <= POS_ID;
      attempt_q <= '0;
      wait_q    <= '0;
      fail_q    <= '0;
      low_q     <= '0;
      high_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      attempt_q <= attempt_d;
      wait_q    <= wait_d;
      fail_q    <= fail_d;
      low_q     <= low_d;
      high_q    <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && is_start) begin
      sv_instr_q <= instruction_i;
      sv_addr_q  <= reg_address_i;
      sv_arg_q   <= argument_i;
      sv_cnt_q   <= arg_count_i;
    end
    if (ld_id)  ans_id_q  <= rx_byte_i;
    if (ld_len) ans_len_q <= rx_byte_i;
    if (ld_err) ans_err_q <= rx_byte_i;
  end

endmodule

### rtl/spte_back.sv
// spte_back: expands queued jobs into output beats (packet bytes, finish beat)
// behind a registered output stage. Depends on spte_pkg.
module spte_back
  import spte_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  cmd_t                   head_cmd_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  output logic [0:0]             m_axis_tuser
);

  step_e       step_q, step_d, step_cur;
  logic        issue;
  logic        beat_kind, beat_last, beat_done;
  logic [7:0]  beat_byte;
  logic [1:0]  beat_status;
  logic [7:0]  beat_err;
  logic [15:0] beat_value;

  logic        out_valid_q;
  logic        out_kind_q, out_last_q;
  logic [7:0]  out_byte_q;
  logic [1:0]  out_status_q;
  logic [7:0]  out_err_q;
  logic [15:0] out_value_q, out_fail_q;

  // finish-only jobs skip straight to the finish beat
  assign step_cur = head_cmd_i.pkt ? step_q : STEP_FIN;
  assign issue    = head_valid_i && (!out_valid_q || m_axis_tready);
  assign pop_o    = issue && beat_done;

  // next step
  always_comb begin
    step_d = step_q;
    if (issue) begin
      unique case (step_cur)
        STEP_SYNC1: step_d = STEP_SYNC2;
        STEP_SYNC2: step_d = STEP_ID;
        STEP_ID:    step_d = STEP_LEN;
        STEP_LEN:   step_d = STEP_INSTR;
        STEP_INSTR: step_d = (head_cmd_i.cnt != 2'd0) ? STEP_ADDR : STEP_CKSUM;
        STEP_ADDR:  step_d = (head_cmd_i.cnt > 2'd1) ? STEP_LO : STEP_CKSUM;
        STEP_LO:    step_d = (head_cmd_i.cnt == 2'd3) ? STEP_HI : STEP_CKSUM;
        STEP_HI:    step_d = STEP_CKSUM;
        STEP_CKSUM: step_d = head_cmd_i.fin ? STEP_FIN : STEP_SYNC1;
        STEP_FIN:   step_d = STEP_SYNC1;
        default:    step_d = STEP_SYNC1;
      endcase
    end
  end

  // beat contents
  always_comb begin
    beat_kind   = KIND_TX;
    beat_byte   = '0;
    beat_done   = 1'b0;
    beat_status = STATUS_OK;
    beat_err    = '0;
    beat_value  = '0;
    unique case (step_cur)
      STEP_SYNC1, STEP_SYNC2: beat_byte = SYNC_BYTE;
      STEP_ID:    beat_byte = head_cmd_i.id;
      STEP_LEN:   beat_byte = 8'd2 + {6'd0, head_cmd_i.cnt};
      STEP_INSTR: beat_byte = head_cmd_i.instr;
      STEP_ADDR:  beat_byte = head_cmd_i.addr;
      STEP_LO:    beat_byte = head_cmd_i.arg[7:0];
      STEP_HI:    beat_byte = head_cmd_i.arg[15:8];
      STEP_CKSUM: begin
        beat_byte = head_cmd_i.cksum;
        beat_done = !head_cmd_i.fin;
      end
      STEP_FIN: begin
        beat_kind   = KIND_FINISH;
        beat_done   = 1'b1;
        beat_status = head_cmd_i.status;
        beat_err    = head_cmd_i.err;
        beat_value  = head_cmd_i.value;
      end
      default: ;
    endcase
    beat_last = beat_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_SYNC1;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= issue || (out_valid_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_kind_q   <= beat_kind;
      out_last_q   <= beat_last;
      out_byte_q   <= beat_byte;
      out_status_q <= beat_status;
      out_err_q    <= beat_err;
      out_value_q  <= beat_value;
      out_fail_q   <= head_cmd_i.failure;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_kind_q;
  assign m_axis_tdata    = {6'd0, out_fail_q, out_value_q, out_err_q, out_status_q,
                            out_byte_q};

  // a packet in progress keeps its job at the queue head
  a_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != STEP_SYNC1) |-> head_valid_i)
    else $error("job left the queue mid-packet");

endmodule
